@@ rtl/in_order_transaction_commit_assert.svh @@
// assertion macros for the in-order transaction commit block
`ifndef IN_ORDER_TRANSACTION_COMMIT_ASSERT_SVH
`define IN_ORDER_TRANSACTION_COMMIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define IOTC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define IOTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/iotc_pkg.sv @@
// shared constants, types and helpers for the in-order transaction commit block
`default_nettype none

package iotc_pkg;

  localparam int ID_W    = 31;
  localparam int CNT_W   = 7;
  localparam int STAT_W  = 2;
  localparam int WINDOW  = 64;
  localparam int IDX_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int WCNT_W  = $clog2(WINDOW + 1);
  localparam int CMP_W   = (WCNT_W > CNT_W) ? WCNT_W : CNT_W;

  localparam logic [CNT_W-1:0]  WARN_RESET = CNT_W'(10);
  localparam logic [CNT_W-1:0]  CNT_MAX    = {CNT_W{1'b1}};

  // result status codes
  localparam logic [STAT_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_BEYOND = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_STALE  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MARK,
    S_ADVANCE,
    S_EMIT
  } state_t;

  // control from the sequencer to the row of done cells
  typedef struct packed {
    logic             shift;
    logic             set;
    logic [IDX_W-1:0] idx;
  } chain_ctrl_t;

  // clamp the internal pending count to the reported width
  function automatic logic [CNT_W-1:0] sat_count(input logic [WCNT_W-1:0] c);
    logic [CMP_W-1:0] wide;
    wide = CMP_W'(c);
    if (wide > CMP_W'(CNT_MAX)) begin
      sat_count = CNT_MAX;
    end else begin
      sat_count = CNT_W'(wide);
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/iotc_cell.sv @@
// one done-map cell: holds the done flag of one id past the read cursor
`default_nettype none

module iotc_cell (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic shift,
  input  wire logic set,
  input  wire logic upper,
  output logic      done
);

  // take the neighbor's flag on a shift, otherwise latch a new completion
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else if (shift) begin
      done <= upper;
    end else if (set) begin
      done <= 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ rtl/iotc_chain.sv @@
// row of done cells that shifts toward the read cursor one place per cycle while shift is set
`default_nettype none

module iotc_chain (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire iotc_pkg::chain_ctrl_t ctrl,
  output logic                     head,
  output logic                     hit
);

  import iotc_pkg::*;

  logic [WINDOW-1:0] done_vec;
  logic [WINDOW-1:0] upper_vec;

  // each cell takes its upper neighbor's flag, the far end refills with not-done
  assign upper_vec = {1'b0, done_vec[WINDOW-1:1]};

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    iotc_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (ctrl.shift),
      .set   (ctrl.set && (ctrl.idx == IDX_W'(i))),
      .upper (upper_vec[i]),
      .done  (done_vec[i])
    );
  end

  // head flag and duplicate check for the addressed id
  assign head = done_vec[0];
  assign hit  = done_vec[ctrl.idx];

endmodule

`default_nettype wire

@@ rtl/in_order_transaction_commit.sv @@
// In-order commit scoreboard. A request (func 0) returns the next free id; a
// completion (func 1) marks its id in a 64-cell done map that shifts toward
// the read cursor one position per cycle, so the cursor advances one id per
// cycle. One item is worked at a time: its result is loaded into the output
// register after the read cursor has stopped, and the next item can transfer
// only after that. The time an item takes grows with k, the number of
// ids the read cursor moves (0 to 64), through that one-place-per-cycle
// shift of the cell row. in_stall is high while an item is in work; a
// finished result waits in the output register while the next item is taken,
// and that next item holds in its last step for as long as the output register
// is still full and stalled. The done map is cleared by reset directly, with
// no clearing pass. warn_threshold may be written only while the block is idle.
`default_nettype none

module in_order_transaction_commit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [iotc_pkg::CNT_W-1:0]    cfg_wdata,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          func,
  input  wire logic [iotc_pkg::ID_W-1:0]     txn_id,
  // output channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [iotc_pkg::ID_W-1:0]          new_id,
  output logic [iotc_pkg::ID_W-1:0]          read_cursor,
  output logic [iotc_pkg::CNT_W-1:0]         pending_count,
  output logic                               stall_warning,
  output logic [iotc_pkg::STAT_W-1:0]        status
);

  import iotc_pkg::*;

  state_t state, state_next;

  logic [ID_W-1:0]   next_free_id;
  logic [ID_W-1:0]   commit_cursor;
  logic [WCNT_W-1:0] waiting_total;
  logic [CNT_W-1:0]  warn_threshold;

  logic [ID_W-1:0]   item_new_id;
  logic [STAT_W-1:0] item_status;
  logic              item_mark;
  logic [IDX_W-1:0]  mark_idx;

  logic              in_xfer;
  logic              out_xfer;
  logic              out_free;
  logic              load_out;
  logic              head;
  logic              hit;
  chain_ctrl_t       ctrl;

  logic [ID_W-1:0]   id_offset;
  logic [STAT_W-1:0] cmp_status;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign out_free = !out_valid || !out_stall;

  // classify a completion by its distance from the read cursor
  always_comb begin
    id_offset = txn_id - commit_cursor;
    if (id_offset == '0 || id_offset[ID_W-1]) begin
      cmp_status = STATUS_STALE;
    end else if (id_offset > ID_W'(WINDOW)) begin
      cmp_status = STATUS_BEYOND;
    end else begin
      cmp_status = STATUS_OK;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (in_xfer) state_next = S_MARK;
      S_MARK:    state_next = S_ADVANCE;
      S_ADVANCE: if (!head) state_next = S_EMIT;
      S_EMIT:    if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctrl.shift = 1'b0;
    ctrl.set   = 1'b0;
    ctrl.idx   = mark_idx;
    load_out   = 1'b0;
    unique case (state)
      S_IDLE:    ;
      S_MARK:    ctrl.set = item_mark && !hit;
      S_ADVANCE: ctrl.shift = head;
      S_EMIT:    load_out = out_free;
      default:   ;
    endcase
  end

  iotc_chain u_chain (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .head (head),
    .hit  (hit)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      next_free_id   <= ID_W'(1);
      commit_cursor  <= '0;
      waiting_total  <= '0;
      warn_threshold <= WARN_RESET;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        warn_threshold <= cfg_wdata;
      end
      if (in_xfer && !func) begin
        next_free_id <= next_free_id + ID_W'(1);
      end
      if (ctrl.set) begin
        waiting_total <= waiting_total + WCNT_W'(1);
      end else if (ctrl.shift) begin
        waiting_total <= waiting_total - WCNT_W'(1);
      end
      if (ctrl.shift) begin
        commit_cursor <= commit_cursor + ID_W'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_xfer) begin
        out_valid <= 1'b0;
      end
    end
  end

  // capture the item on its transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      if (!func) begin
        item_new_id <= next_free_id;
        item_status <= STATUS_OK;
        item_mark   <= 1'b0;
      end else begin
        item_new_id <= '0;
        item_status <= cmp_status;
        item_mark   <= (cmp_status == STATUS_OK);
      end
      mark_idx <= IDX_W'(id_offset - ID_W'(1));
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      new_id        <= item_new_id;
      read_cursor   <= commit_cursor;
      pending_count <= sat_count(waiting_total);
      stall_warning <= (CMP_W'(waiting_total) > CMP_W'(warn_threshold));
      status        <= item_status;
    end
  end

  `include "in_order_transaction_commit_assert.svh"

  `IOTC_ASSERT_NOW(a_count_in_window, 1'b1, waiting_total <= WCNT_W'(WINDOW),
                   "pending count beyond window")
  `IOTC_ASSERT_NOW(a_emit_head_clear, state == S_EMIT, !head,
                   "result formed while head id is done")
  `IOTC_ASSERT_NEXT(a_shift_moves_cursor, ctrl.shift,
                    commit_cursor == $past(commit_cursor) + ID_W'(1),
                    "cursor did not follow shift")
  `IOTC_ASSERT_NEXT(a_request_advances, in_xfer && !func,
                    next_free_id == $past(next_free_id) + ID_W'(1),
                    "free id did not advance")

endmodule

`default_nettype wire

@@ tb/sv/commit_tb_pkg.sv @@
// operation codes shared by the commit scoreboard testbench files
`timescale 1ns / 1ps

package commit_tb_pkg;

  // func field of an input transfer
  localparam logic FUNC_REQUEST  = 1'b0;
  localparam logic FUNC_COMPLETE = 1'b1;

endpackage

@@ tb/sv/commit_window_check.sv @@
// predicts and checks every result of the in-order transaction commit block
`timescale 1ns / 1ps

module commit_window_check (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [iotc_pkg::CNT_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          func,
  input  logic [iotc_pkg::ID_W-1:0]     txn_id,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [iotc_pkg::ID_W-1:0]     new_id,
  input  logic [iotc_pkg::ID_W-1:0]     read_cursor,
  input  logic [iotc_pkg::CNT_W-1:0]    pending_count,
  input  logic                          stall_warning,
  input  logic [iotc_pkg::STAT_W-1:0]   status,
  output int                            error_count,
  output int                            results_owed,
  output logic [iotc_pkg::ID_W-1:0]     cursor_now
);
  import iotc_pkg::*;
  import commit_tb_pkg::*;

  typedef struct packed {
    logic [ID_W-1:0]   new_id;
    logic [ID_W-1:0]   read_cursor;
    logic [CNT_W-1:0]  pending_count;
    logic              stall_warning;
    logic [STAT_W-1:0] status;
  } commit_result_t;

  localparam logic [ID_W-1:0] HALF_SPACE = ID_W'(32'h4000_0000);

  // shadow of the scoreboard state
  logic [CNT_W-1:0]  warn_limit;
  logic [ID_W-1:0]   next_id;
  logic [ID_W-1:0]   commit_pos;
  logic [WINDOW-1:0] done_bits;
  int                waiting_ct;
  int                mismatch_ct;
  commit_result_t    owed_q[$];

  // apply one transfer to the shadow state and return the result it owes
  function automatic commit_result_t apply_item(input logic op, input logic [ID_W-1:0] id);
    commit_result_t r;
    logic [ID_W-1:0] id_offset;
    r = '0;
    r.status = STATUS_OK;
    if (op == FUNC_REQUEST) begin
      r.new_id = next_id;
      next_id = next_id + 1'b1;
    end else begin
      id_offset = id - commit_pos;
      if (id_offset == '0 || id_offset >= HALF_SPACE) begin
        r.status = STATUS_STALE;
      end else if (id_offset > ID_W'(WINDOW)) begin
        r.status = STATUS_BEYOND;
      end else begin
        if (!done_bits[id_offset - 1'b1]) begin
          done_bits[id_offset - 1'b1] = 1'b1;
          waiting_ct++;
        end
        // walk the read cursor over every id already done
        while (done_bits[0]) begin
          done_bits = done_bits >> 1;
          commit_pos = commit_pos + 1'b1;
          waiting_ct--;
        end
      end
    end
    r.read_cursor = commit_pos;
    r.pending_count = (waiting_ct > int'(CNT_MAX)) ? CNT_MAX : CNT_W'(waiting_ct);
    r.stall_warning = (waiting_ct > int'(warn_limit));
    return r;
  endfunction

  always @(posedge clk) begin : watch
    commit_result_t want;
    commit_result_t got;
    if (rst) begin
      warn_limit = WARN_RESET;
      next_id = ID_W'(1);
      commit_pos = '0;
      done_bits = '0;
      waiting_ct = 0;
      owed_q.delete();
    end else begin
      if (cfg_we) begin
        warn_limit = cfg_wdata;
      end
      // compare a result transfer with the oldest owed result
      if (out_valid && !out_stall) begin
        got.new_id = new_id;
        got.read_cursor = read_cursor;
        got.pending_count = pending_count;
        got.stall_warning = stall_warning;
        got.status = status;
        if (owed_q.size() == 0) begin
          mismatch_ct++;
          if (mismatch_ct <= 10) begin
            $display("commit check: unexpected result new_id %0d cursor %0d pending %0d",
                     new_id, read_cursor, pending_count);
          end
        end else begin
          want = owed_q.pop_front();
          if (got !== want) begin
            mismatch_ct++;
            if (mismatch_ct <= 10) begin
              $display("commit check: expected new_id %0d cursor %0d pending %0d warn %0b st %0d",
                       want.new_id, want.read_cursor, want.pending_count,
                       want.stall_warning, want.status);
              $display("commit check:      got new_id %0d cursor %0d pending %0d warn %0b st %0d",
                       got.new_id, got.read_cursor, got.pending_count,
                       got.stall_warning, got.status);
            end
          end
        end
      end
      // predict the result of an input transfer
      if (in_valid && !in_stall) begin
        owed_q.insert(owed_q.size(), apply_item(func, txn_id));
      end
    end
    error_count <= mismatch_ct;
    results_owed <= owed_q.size();
    cursor_now <= commit_pos;
  end

endmodule

@@ tb/sv/testbench.sv @@
// stimulus, idling and verdict for the in-order transaction commit block
`timescale 1ns / 1ps

module testbench;
  import iotc_pkg::*;
  import commit_tb_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  // receiver stall patterns
  localparam int STALL_NONE     = 0;
  localparam int STALL_LIGHT    = 1;
  localparam int STALL_HEAVY    = 2;
  localparam int STALL_PERIODIC = 3;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [CNT_W-1:0]  cfg_wdata;
  logic              in_valid;
  logic              in_stall;
  logic              func;
  logic [ID_W-1:0]   txn_id;
  logic              out_valid;
  logic              out_stall;
  logic [ID_W-1:0]   new_id;
  logic [ID_W-1:0]   read_cursor;
  logic [CNT_W-1:0]  pending_count;
  logic              stall_warning;
  logic [STAT_W-1:0] status;

  int                error_count;
  int                results_owed;
  logic [ID_W-1:0]   cursor_now;

  int                sent_count;
  int                burst_left;
  int                idle_cycles;
  logic [ID_W-1:0]   issued_next;
  logic [ID_W-1:0]   open_ids[$];
  logic [ID_W-1:0]   recent_ids[$];

  in_order_transaction_commit dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .txn_id         (txn_id),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .new_id         (new_id),
    .read_cursor    (read_cursor),
    .pending_count  (pending_count),
    .stall_warning  (stall_warning),
    .status         (status)
  );

  commit_window_check window_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .txn_id         (txn_id),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .new_id         (new_id),
    .read_cursor    (read_cursor),
    .pending_count  (pending_count),
    .stall_warning  (stall_warning),
    .status         (status),
    .error_count    (error_count),
    .results_owed   (results_owed),
    .cursor_now     (cursor_now)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("testbench: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // offer one item and wait for its transfer, then maybe idle between bursts
  task automatic offer(input logic op, input logic [ID_W-1:0] id);
    int unsigned gap;
    @(negedge clk);
    in_valid <= 1'b1;
    func <= op;
    txn_id <= id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
    if (burst_left > 1) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // request a new id; the id field carries random noise
  task automatic issue();
    issued_next = issued_next + 1'b1;
    offer(FUNC_REQUEST, ID_W'($urandom()));
  endtask

  // stop offering and wait until every owed result has come back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [CNT_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly requests and out-of-order completions of issued ids, some noise
  task automatic random_item();
    int unsigned pick;
    int unsigned k;
    logic [ID_W-1:0] id_offset;
    logic want_req;
    pick = $urandom_range(0, 99);
    id_offset = issued_next - cursor_now;
    want_req = (open_ids.size() == 0) ? (pick < 85) : (pick < 40);
    if (want_req && (id_offset < ID_W'(60) || id_offset >= ID_W'(32'h4000_0000))) begin
      open_ids.insert(open_ids.size(), issued_next);
      issue();
    end else if (pick < 85 && open_ids.size() != 0) begin
      k = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(0, open_ids.size() - 1);
      recent_ids.insert(recent_ids.size(), open_ids[k]);
      if (recent_ids.size() > 8) void'(recent_ids.pop_front());
      offer(FUNC_COMPLETE, open_ids[k]);
      open_ids.delete(k);
    end else if (pick < 90 && recent_ids.size() != 0) begin
      offer(FUNC_COMPLETE, recent_ids[$urandom_range(0, recent_ids.size() - 1)]);
    end else begin
      case ($urandom_range(0, 4))
        0: offer(FUNC_COMPLETE, ID_W'($urandom()));
        1: offer(FUNC_COMPLETE, cursor_now + ID_W'(WINDOW) + ID_W'($urandom_range(1, 2000)));
        2: offer(FUNC_COMPLETE, cursor_now - ID_W'($urandom_range(0, 50)));
        3: offer(FUNC_COMPLETE, cursor_now + ID_W'($urandom_range(1, WINDOW)));
        default: offer(FUNC_COMPLETE,
                       cursor_now + ID_W'(32'h4000_0000) - ID_W'($urandom_range(0, 1)));
      endcase
    end
  endtask

  // receiver: changing stall patterns plus two long hold-offs
  initial begin : receiver
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned tick;
    bit first_hold;
    bit second_hold;
    out_stall = 1'b0;
    mode = STALL_NONE;
    mode_left = 0;
    hold_left = 0;
    tick = 0;
    first_hold = 1'b0;
    second_hold = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (!first_hold && sent_count >= 120) begin
        first_hold = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (!second_hold && sent_count >= 330) begin
        second_hold = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(STALL_NONE, STALL_PERIODIC);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
          default:     out_stall <= ((tick % 8) < 3);
        endcase
      end
    end
  end

  initial begin : stimulus
    int ph;
    int k;
    logic [CNT_W-1:0] limit;
    logic [ID_W-1:0] base;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    func = FUNC_REQUEST;
    txn_id = '0;
    sent_count = 0;
    burst_left = 1;
    issued_next = ID_W'(1);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: stale at the cursor, completion before issue, window edges
    offer(FUNC_COMPLETE, ID_W'(0));
    offer(FUNC_COMPLETE, ID_W'(1));
    repeat (3) issue();
    offer(FUNC_COMPLETE, ID_W'(65));
    offer(FUNC_COMPLETE, ID_W'(66));
    offer(FUNC_COMPLETE, ID_W'(32'h4000_0000));
    offer(FUNC_COMPLETE, ID_W'(32'h4000_0001));
    offer(FUNC_COMPLETE, ID_W'(32'h7FFF_FFFF));
    // pending, duplicate, then the cursor walks over it
    offer(FUNC_COMPLETE, ID_W'(3));
    offer(FUNC_COMPLETE, ID_W'(3));
    offer(FUNC_COMPLETE, ID_W'(2));
    offer(FUNC_COMPLETE, ID_W'(1));
    // push the pending count past the reset threshold, then release it
    for (k = 5; k <= 14; k++) offer(FUNC_COMPLETE, ID_W'(k));
    offer(FUNC_COMPLETE, ID_W'(4));
    settle();

    // random phases, one threshold each
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: limit = CNT_W'(0);
        1: limit = CNT_W'(64);
        2: limit = CNT_W'(63);
        3: limit = CNT_W'($urandom_range(1, 62));
        default: limit = CNT_W'(5);
      endcase
      write_threshold(limit);
      repeat (80) random_item();
      settle();
    end

    // fill the whole window backward, then one transfer walks all of it
    write_threshold(CNT_W'(62));
    base = cursor_now;
    for (k = WINDOW; k >= 2; k--) offer(FUNC_COMPLETE, base + ID_W'(k));
    offer(FUNC_COMPLETE, base + ID_W'(1));
    settle();

    repeat (80) @(posedge clk);
    if (error_count == 0 && results_owed == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/iotc_pkg.sv
rtl/iotc_cell.sv
rtl/iotc_chain.sv
rtl/in_order_transaction_commit.sv
tb/sv/commit_tb_pkg.sv
tb/sv/commit_window_check.sv
tb/sv/testbench.sv
